FILE: rtl/core/value_noise_3d_macros.svh
// Assertion helpers used by the checker of the noise block
`ifndef VALUE_NOISE_3D_MACROS_SVH
`define VALUE_NOISE_3D_MACROS_SVH

// Consequent must hold at the same edge as the antecedent
`define VN_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold at the edge after the antecedent
`define VN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/vn_pkg.sv
package vn_pkg;

    // Hash weights, all arithmetic wraps at 32 bits
    localparam logic [31:0] VN_K_X    = 32'd1619;
    localparam logic [31:0] VN_K_Y    = 32'd9473;
    localparam logic [31:0] VN_K_Z    = 32'd31337;
    localparam logic [31:0] VN_K_SEED = 32'd6971;
    localparam logic [31:0] VN_K_MIX  = 32'hbf58476d;

    // 3.0 in Q2.16 for the smoothstep factor (3 - 2t)
    localparam logic [17:0] VN_EASE_THREE = 18'd196608;

    typedef logic [31:0]       vn_word_t;
    typedef logic [2:0][15:0]  vn_ease3_t;
    typedef logic [7:0][31:0]  vn_corners_t;

    // Pipeline control handed to each section
    typedef struct packed {
        logic adv;
        logic vld;
    } vn_ctl_t;

endpackage

FILE: rtl/core/value_noise_3d.sv
// 3D value noise, one request per clock. Each request carries a Q16.16 point,
// a Q2.16 scale and a seed; the result is the trilinearly blended lattice value
// in unsigned Q0.24. The pipeline is seven register stages deep: scale, split and
// square, smoothstep and first xorshift, hash multiply, x blend, y blend, z blend.
// A new request is taken every cycle in which the output register is empty or
// being taken, so throughput is one result per cycle while results are taken;
// a stall at the output freezes every stage, and nothing is dropped or repeated.
module value_noise_3d import vn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pos_x,
    input  logic [31:0] s_pos_y,
    input  logic [31:0] s_pos_z,
    input  logic [17:0] s_lattice_scale,
    input  logic [31:0] s_noise_seed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_noise_value
);

    logic        adv;
    logic        lat_vld, mix_vld, out_vld;
    vn_ctl_t     lat_ctl, mix_ctl, blend_ctl;
    vn_corners_t corner_pre, corner_mix;
    vn_ease3_t   ease_lat, ease_mix;

    // Advance the whole pipeline whenever the output register can move on
    assign adv     = !out_vld || m_ready;
    assign s_ready = adv;

    assign lat_ctl   = '{adv: adv, vld: s_valid};
    assign mix_ctl   = '{adv: adv, vld: lat_vld};
    assign blend_ctl = '{adv: adv, vld: mix_vld};

    vn_lattice u_lattice (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (lat_ctl),
        .pos_x         (s_pos_x),
        .pos_y         (s_pos_y),
        .pos_z         (s_pos_z),
        .lattice_scale (s_lattice_scale),
        .noise_seed    (s_noise_seed),
        .corner_pre    (corner_pre),
        .ease          (ease_lat),
        .vld           (lat_vld)
    );

    vn_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mix_ctl),
        .corner_pre (corner_pre),
        .ease_in    (ease_lat),
        .corner_mix (corner_mix),
        .ease_out   (ease_mix),
        .vld        (mix_vld)
    );

    vn_blend u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (blend_ctl),
        .corner_mix  (corner_mix),
        .ease        (ease_mix),
        .noise_value (m_noise_value),
        .vld         (out_vld)
    );

    assign m_valid = out_vld;

endmodule

FILE: rtl/core/vn_lattice.sv
module vn_lattice import vn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  vn_ctl_t     ctl,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [17:0] lattice_scale,
    input  logic [31:0] noise_seed,
    output vn_corners_t corner_pre,
    output vn_ease3_t   ease,
    output logic        vld
);

    // Hash offset of a corner: bit 0 steps x, bit 1 steps y, bit 2 steps z
    function automatic vn_word_t corner_offset(input logic [2:0] c);
        vn_word_t ox, oy, oz;
        ox = c[0] ? VN_K_X : '0;
        oy = c[1] ? VN_K_Y : '0;
        oz = c[2] ? VN_K_Z : '0;
        return ox + oy + oz;
    endfunction

    logic [2:0][31:0] pos;
    logic [2:0][50:0] prod;
    logic [2:0][31:0] v1_next, v1_reg;
    vn_word_t         seed1_reg;
    logic             vld1_reg;

    logic [2:0][31:0] lat_int;
    logic [2:0][31:0] tt2_next, tt2_reg;
    logic [2:0][15:0] t2_reg;
    vn_word_t         base2_next, base2_reg;
    logic             vld2_reg;

    logic [2:0][17:0] fac;
    logic [2:0][49:0] ez;
    vn_ease3_t        s3_next, s3_reg;
    vn_corners_t      pre3_next, pre3_reg;
    vn_word_t         h;
    logic             vld3_reg;

    assign pos = {pos_z, pos_y, pos_x};

    // Scale each coordinate and floor back to Q16.16
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i]    = $signed(pos[i]) * $signed({1'b0, lattice_scale});
            v1_next[i] = prod[i][47:16];
        end
    end

    // Split into lattice cell and fraction, square the fraction, sum the hash base
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lat_int[i]  = {{16{v1_reg[i][31]}}, v1_reg[i][31:16]};
            tt2_next[i] = v1_reg[i][15:0] * v1_reg[i][15:0];
        end
        base2_next = lat_int[0] * VN_K_X + lat_int[1] * VN_K_Y + lat_int[2] * VN_K_Z
                   + seed1_reg * VN_K_SEED;
    end

    // Finish smoothstep and give each corner its first xorshift
    always_comb begin
        h = '0;
        for (int i = 0; i < 3; i++) begin
            fac[i]     = VN_EASE_THREE - {t2_reg[i], 1'b0};
            ez[i]      = tt2_reg[i] * fac[i];
            s3_next[i] = ez[i][47:32];
        end
        for (int c = 0; c < 8; c++) begin
            h            = base2_reg + corner_offset(3'(c));
            pre3_next[c] = h ^ (h >> 13);
        end
    end

    // Advance valid bits with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (ctl.adv) begin
            vld1_reg <= ctl.vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // Advance payload, hold on stall
    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            v1_reg    <= v1_next;
            seed1_reg <= noise_seed;
            tt2_reg   <= tt2_next;
            for (int i = 0; i < 3; i++) begin
                t2_reg[i] <= v1_reg[i][15:0];
            end
            base2_reg <= base2_next;
            s3_reg    <= s3_next;
            pre3_reg  <= pre3_next;
        end
    end

    assign corner_pre = pre3_reg;
    assign ease       = s3_reg;
    assign vld        = vld3_reg;

endmodule

FILE: rtl/core/vn_mix.sv
module vn_mix import vn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  vn_ctl_t     ctl,
    input  vn_corners_t corner_pre,
    input  vn_ease3_t   ease_in,
    output vn_corners_t corner_mix,
    output vn_ease3_t   ease_out,
    output logic        vld
);

    vn_corners_t mix_next, mix_reg;
    vn_ease3_t   s_reg;
    logic        vld_reg;

    // Multiply every corner by the mixing constant, keep the low word
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            mix_next[c] = corner_pre[c] * VN_K_MIX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ctl.adv) begin
            vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            mix_reg <= mix_next;
            s_reg   <= ease_in;
        end
    end

    assign corner_mix = mix_reg;
    assign ease_out   = s_reg;
    assign vld        = vld_reg;

endmodule

FILE: rtl/core/vn_blend.sv
module vn_blend import vn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  vn_ctl_t     ctl,
    input  vn_corners_t corner_mix,
    input  vn_ease3_t   ease,
    output logic [23:0] noise_value,
    output logic        vld
);

    // a + floor((b - a) * s / 2^16); always lies between a and b
    function automatic logic [23:0] lerp(input logic [23:0] a, input logic [23:0] b,
                                         input logic [15:0] s);
        logic signed [24:0] d;
        logic signed [41:0] p;
        logic        [25:0] step;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        p    = d * $signed({1'b0, s});
        step = p[41:16];
        return a + step[23:0];
    endfunction

    logic [7:0][23:0] cv;
    vn_word_t         g;
    logic [3:0][23:0] ax_next, ax_reg;
    logic [15:0]      sy5_reg, sz5_reg, sz6_reg;
    logic [1:0][23:0] by_next, by_reg;
    logic [23:0]      out_next, out_reg;
    logic             vld5_reg, vld6_reg, vld7_reg;

    // Final xorshift, take the Q0.24 value, blend along x
    always_comb begin
        g = '0;
        for (int c = 0; c < 8; c++) begin
            g     = corner_mix[c] ^ (corner_mix[c] >> 31);
            cv[c] = g[23:0];
        end
        for (int k = 0; k < 4; k++) begin
            ax_next[k] = lerp(cv[2*k], cv[2*k+1], ease[0]);
        end
    end

    // Blend along y, then z
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            by_next[j] = lerp(ax_reg[2*j], ax_reg[2*j+1], sy5_reg);
        end
        out_next = lerp(by_reg[0], by_reg[1], sz6_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
        end else if (ctl.adv) begin
            vld5_reg <= ctl.vld;
            vld6_reg <= vld5_reg;
            vld7_reg <= vld6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            ax_reg  <= ax_next;
            sy5_reg <= ease[1];
            sz5_reg <= ease[2];
            by_reg  <= by_next;
            sz6_reg <= sz5_reg;
            out_reg <= out_next;
        end
    end

    assign noise_value = out_reg;
    assign vld         = vld7_reg;

endmodule

FILE: rtl/core/vn_checker.sv
`include "value_noise_3d_macros.svh"

module vn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_noise_value
);

    // Take requests whenever the output side can drain
    `VN_ASSERT_SAME(a_ready_when_free, aclk, aresetn, !m_valid || m_ready, s_ready, "request refused while output free")

    // Back-pressure only comes from a held result
    `VN_ASSERT_NEXT(a_stall_keeps_result, aclk, aresetn, !s_ready, m_valid, "stall without a held result")

    `VN_ASSERT_NEXT(a_valid_held, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped before taken")

    `VN_ASSERT_NEXT(a_value_held, aclk, aresetn, m_valid && !m_ready, $stable(m_noise_value), "result changed while stalled")

endmodule

bind value_noise_3d vn_checker u_vn_checker (.*);

FILE: tb/tb_top.sv
module tb_top;
    import vn_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned N_RANDOM    = 1150;
    localparam logic [17:0] SCALE_ONE   = 18'd65536;
    localparam logic [17:0] SCALE_MAX   = 18'h3FFFF;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [17:0] scale;
        logic [31:0] seed;
        int unsigned gap;
    } noise_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_pos_x = '0;
    logic [31:0] s_pos_y = '0;
    logic [31:0] s_pos_z = '0;
    logic [17:0] s_lattice_scale = '0;
    logic [31:0] s_noise_seed = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_noise_value;

    noise_req_t  pending_reqs[$];
    logic [23:0] expected_noise[$];
    noise_req_t  cur_req;

    bit          in_fire = 1'b0;
    bit          out_fire = 1'b0;
    bit          rx_hold = 1'b0;
    bit          rx_calm = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_wait = 0;
    int unsigned n_added = 0;
    int unsigned n_req = 0;
    int unsigned n_res = 0;
    int unsigned n_bad = 0;
    int unsigned hold_stalls = 0;

    value_noise_3d i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_pos_z         (s_pos_z),
        .s_lattice_scale (s_lattice_scale),
        .s_noise_seed    (s_noise_seed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_noise_value   (m_noise_value)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Scale a Q16.16 coordinate by a Q2.16 factor, floor back to Q16.16, wrap to 32 bits
    function automatic logic [31:0] scaled_coord(logic [31:0] p, logic [17:0] k);
        longint      prod;
        logic [63:0] bits;
        prod = longint'(signed'(p)) * longint'(k);
        bits = prod;
        return bits[47:16];
    endfunction

    // Smoothstep t*t*(3-2t) on a Q0.16 fraction, truncated once
    function automatic logic [15:0] eased_frac(logic [15:0] t);
        logic [63:0] tw;
        logic [63:0] r;
        tw = {48'b0, t};
        r = tw * tw * (64'(VN_EASE_THREE) - 64'd2 * tw);
        return r[47:32];
    endfunction

    function automatic logic [23:0] corner_hash(logic [31:0] cx, logic [31:0] cy,
                                                logic [31:0] cz, logic [31:0] seed);
        logic [31:0] h;
        h = cx * VN_K_X + cy * VN_K_Y + cz * VN_K_Z + seed * VN_K_SEED;
        h = h ^ (h >> 13);
        h = h * VN_K_MIX;
        h = h ^ (h >> 31);
        return h[23:0];
    endfunction

    // a + ((b - a) * s >>> 16), floor on the shift
    function automatic logic [23:0] blend(logic [23:0] a, logic [23:0] b, logic [15:0] s);
        longint diff;
        longint step;
        diff = longint'(b) - longint'(a);
        step = (diff * longint'(s)) >>> 16;
        return 24'(longint'(a) + step);
    endfunction

    function automatic logic [23:0] noise_at(noise_req_t r);
        logic [31:0] vx, vy, vz;
        logic [31:0] x0, y0, z0, x1, y1, z1;
        logic [15:0] sx, sy, sz;
        logic [23:0] a0, a1, a2, a3, b0, b1;
        vx = scaled_coord(r.px, r.scale);
        vy = scaled_coord(r.py, r.scale);
        vz = scaled_coord(r.pz, r.scale);
        x0 = {{16{vx[31]}}, vx[31:16]};
        y0 = {{16{vy[31]}}, vy[31:16]};
        z0 = {{16{vz[31]}}, vz[31:16]};
        x1 = x0 + 32'd1;
        y1 = y0 + 32'd1;
        z1 = z0 + 32'd1;
        sx = eased_frac(vx[15:0]);
        sy = eased_frac(vy[15:0]);
        sz = eased_frac(vz[15:0]);
        a0 = blend(corner_hash(x0, y0, z0, r.seed), corner_hash(x1, y0, z0, r.seed), sx);
        a1 = blend(corner_hash(x0, y1, z0, r.seed), corner_hash(x1, y1, z0, r.seed), sx);
        a2 = blend(corner_hash(x0, y0, z1, r.seed), corner_hash(x1, y0, z1, r.seed), sx);
        a3 = blend(corner_hash(x0, y1, z1, r.seed), corner_hash(x1, y1, z1, r.seed), sx);
        b0 = blend(a0, a1, sy);
        b1 = blend(a2, a3, sy);
        return blend(b0, b1, sz);
    endfunction

    task automatic add_req(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [17:0] scale, logic [31:0] seed, int unsigned gap);
        noise_req_t r;
        r.px = px;
        r.py = py;
        r.pz = pz;
        r.scale = scale;
        r.seed = seed;
        r.gap = gap;
        pending_reqs = {pending_reqs, r};
        n_added++;
    endtask

    // Sample both handshakes, predict accepted requests, check returned results
    always @(posedge aclk) begin
        in_fire = aresetn && s_valid && s_ready;
        out_fire = aresetn && m_valid && m_ready;
        if (in_fire) begin
            cur_req.px = s_pos_x;
            cur_req.py = s_pos_y;
            cur_req.pz = s_pos_z;
            cur_req.scale = s_lattice_scale;
            cur_req.seed = s_noise_seed;
            expected_noise = {expected_noise, noise_at(cur_req)};
            n_req++;
        end
        if (out_fire) begin
            n_res++;
            if (expected_noise.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result noise_value=%06h", m_noise_value);
            end else if (m_noise_value !== expected_noise[0]) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("result %0d: noise_value expected %06h got %06h",
                             n_res, expected_noise[0], m_noise_value);
                void'(expected_noise.pop_front());
            end else begin
                void'(expected_noise.pop_front());
            end
        end
    end

    // Offer requests at the falling edge; hold each until taken, then idle for its gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                noise_req_t r;
                r = pending_reqs.pop_front();
                s_pos_x <= r.px;
                s_pos_y <= r.py;
                s_pos_z <= r.pz;
                s_lattice_scale <= r.scale;
                s_noise_seed <= r.seed;
                s_valid <= 1'b1;
                tx_gap = r.gap;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result side per result, with calm stretches and one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (out_fire) begin
                if ($urandom_range(0, 63) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_hold;
            end
        end
    end

    // Long hold-off so the pipeline fills and back-pressures the request side
    initial begin
        while (n_req < 300)
            @(negedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) begin
            @(negedge aclk);
            if (s_valid && !s_ready)
                hold_stalls++;
        end
        rx_hold = 1'b0;
    end

    // Abort when neither side moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_noise.size());
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        int unsigned kind;
        int unsigned gap;
        bit          calm;
        logic [31:0] p[3];
        logic [17:0] k;
        logic [15:0] hi;
        logic [31:0] edges[4];

        edges[0] = 32'h7FFF_FFFF;
        edges[1] = 32'h8000_0000;
        edges[2] = 32'h0000_0000;
        edges[3] = 32'hFFFF_FFFF;

        // Directed: field extremes, lattice edges, wrap of scaled products
        add_req(32'h0, 32'h0, 32'h0, 18'h0, 32'h0, 0);
        add_req(32'h0, 32'h0, 32'h0, SCALE_ONE, 32'h0, 0);
        add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, SCALE_MAX, 32'h7FFF_FFFF, 0);
        add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, SCALE_MAX, 32'h8000_0000, 0);
        add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, SCALE_ONE, 32'h1234_5678, 0);
        add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, SCALE_ONE, 32'hFFFF_FFFF, 0);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SCALE_ONE, 32'h1, 0);
        add_req(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, SCALE_ONE, 32'hDEAD_BEEF, 0);
        add_req(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, SCALE_ONE, 32'h0, 0);
        add_req(32'h7FFF_FFFF, 32'h4000_0000, 32'h0001_2345, 18'd1, 32'h5555_5555, 1);
        add_req(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFE_1234, 18'd1, 32'hAAAA_AAAA, 2);
        add_req(32'h4000_0000, 32'hC000_0000, 32'h2000_0000, SCALE_MAX, 32'h8000_0001, 0);
        add_req(32'hFFF0_0001, 32'h000F_FFFF, 32'h7FFF_0000, SCALE_ONE, 32'h7FFF_FFFF, 3);
        add_req(32'h0000_7FFF, 32'hFFFF_8001, 32'h0000_FFFF, 18'd131072, 32'h0000_0001, 0);
        add_req(32'h0000_0001, 32'h0000_FFFF, 32'hFFFF_0001, SCALE_ONE, 32'h0F0F_F0F0, 7);
        add_req(32'h3FFF_FFFF, 32'hBFFF_FFFF, 32'h0000_0000, 18'h2_0001, 32'hFFFF_0000, 0);
        add_req(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 18'h1_FFFF, 32'h0000_FFFF, 5);

        // Random: unit scale near the origin or at fraction edges, plus full-range and edge points
        calm = 1'b0;
        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 9);
            for (int a = 0; a < 3; a++) begin
                case (kind)
                    0, 1, 2, 3: begin
                        p[a] = 32'($urandom_range(0, 32'h7F_FFFF)) - 32'h40_0000;
                    end
                    8: begin
                        hi = 16'($urandom_range(0, 65535));
                        case ($urandom_range(0, 2))
                            0: p[a] = {hi, 16'hFFFF};
                            1: p[a] = {hi, 16'h0000};
                            default: p[a] = {hi, 16'h0001};
                        endcase
                    end
                    9: p[a] = edges[$urandom_range(0, 3)];
                    default: p[a] = $urandom;
                endcase
            end
            case (kind)
                0, 1, 2, 3, 8: k = SCALE_ONE;
                4, 5: k = 18'($urandom);
                6, 7: k = 18'($urandom_range(0, 18'h1_FFFF));
                default: begin
                    case ($urandom_range(0, 3))
                        0: k = 18'h0;
                        1: k = 18'd1;
                        2: k = SCALE_MAX;
                        default: k = 18'($urandom);
                    endcase
                end
            endcase
            if ($urandom_range(0, 49) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 7);
            add_req(p[0], p[1], p[2], k, $urandom, gap);
        end

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: every request returned as a result, then a short tail
        do
            @(negedge aclk);
        while (n_res < n_added);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("covered %0d requests and %0d results, directed edges then random points",
                 n_req, n_res);
        $display("long output hold-off stalled the request side for %0d cycles; mismatches %0d",
                 hold_stalls, n_bad);
        if (n_bad == 0 && expected_noise.size() == 0 && n_res == n_added)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
